// ----- design/scd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, codes and lookup functions for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int KEY_W  = 7;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SLOT_W-1:0] ring_slot_t;
  typedef logic [CNT_W-1:0]  skip_cnt_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_CLASS = 2'd2
  } mode_t;

  localparam logic [7:0] CODE_EXT0   = 8'hE0;
  localparam logic [7:0] CODE_EXT1   = 8'hE1;
  localparam logic [7:0] CODE_PRTSC  = 8'h37;

  localparam skip_cnt_t SKIP_PLAIN = 3'd1;
  localparam skip_cnt_t SKIP_SHORT = 3'd2;
  localparam skip_cnt_t SKIP_PRTSC = 3'd4;
  localparam skip_cnt_t SKIP_EXT1  = 3'd5;
  localparam skip_cnt_t SKIP_LONG  = 3'd6;

  // One controller poll as registered at the input.
  typedef struct packed {
    logic       data_ready;
    logic       timeout_error;
    logic       parity_error;
    logic [7:0] scan_byte;
  } poll_t;

  // One decoded character headed for the result register.
  typedef struct packed {
    key_t       key_code;
    ring_slot_t ring_slot;
  } result_t;

  // Map a make code to its character; zero means no output.
  function automatic key_t map_code(input logic [7:0] code);
    key_t ch;
    ch = '0;
    unique case (code)
      8'h01: ch = 7'h1B;
      8'h02: ch = 7'h31;
      8'h03: ch = 7'h32;
      8'h04: ch = 7'h33;
      8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;
      8'h07: ch = 7'h36;
      8'h08: ch = 7'h37;
      8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;
      8'h0B: ch = 7'h30;
      8'h0C: ch = 7'h2D;
      8'h0D: ch = 7'h3D;
      8'h0E: ch = 7'h08;
      8'h0F: ch = 7'h09;
      8'h10: ch = 7'h51;
      8'h11: ch = 7'h57;
      8'h12: ch = 7'h45;
      8'h13: ch = 7'h52;
      8'h14: ch = 7'h54;
      8'h15: ch = 7'h59;
      8'h16: ch = 7'h55;
      8'h17: ch = 7'h49;
      8'h18: ch = 7'h4F;
      8'h19: ch = 7'h50;
      8'h1A: ch = 7'h5B;
      8'h1B: ch = 7'h5D;
      8'h1C: ch = 7'h0A;
      8'h1E: ch = 7'h41;
      8'h1F: ch = 7'h53;
      8'h20: ch = 7'h44;
      8'h21: ch = 7'h46;
      8'h22: ch = 7'h47;
      8'h23: ch = 7'h48;
      8'h24: ch = 7'h4A;
      8'h25: ch = 7'h4B;
      8'h26: ch = 7'h4C;
      8'h27: ch = 7'h3B;
      8'h28: ch = 7'h27;
      8'h2B: ch = 7'h5C;
      8'h2C: ch = 7'h5A;
      8'h2D: ch = 7'h58;
      8'h2E: ch = 7'h43;
      8'h2F: ch = 7'h56;
      8'h30: ch = 7'h42;
      8'h31: ch = 7'h4E;
      8'h32: ch = 7'h4D;
      8'h33: ch = 7'h2C;
      8'h34: ch = 7'h2E;
      8'h35: ch = 7'h2F;
      8'h39: ch = 7'h20;
      8'h4B: ch = 7'd3;
      8'h4D: ch = 7'd2;
      8'h50: ch = 7'd1;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // Class bytes after an E0 prefix that are followed by two more reads.
  function automatic logic short_class(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (b) inside
      8'h38, 8'h1D, 8'hB8, 8'h9D, 8'h52, 8'h47, 8'h49, 8'h53,
      8'h4F, 8'h51, 8'h35, 8'h1C, 8'h5B, 8'h5C, 8'h5D: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

// ----- design/scd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_if
// Valid/ready channels for controller polls and decoded characters.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic       data_ready;
  logic       timeout_error;
  logic       parity_error;
  logic [7:0] scan_byte;

  modport source (output valid, data_ready, timeout_error, parity_error, scan_byte,
                  input ready);
  modport sink   (input valid, data_ready, timeout_error, parity_error, scan_byte,
                  output ready);
endinterface

interface scd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_code;
  logic [3:0] ring_slot;

  modport source (output valid, key_code, ring_slot, input ready);
  modport sink   (input valid, key_code, ring_slot, output ready);
endinterface
`default_nettype wire

// ----- design/scd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_in_stage
// Input register: hold one accepted poll until the decoder consumes it.
// ----------------------------------------------------------------------------
module scd_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire scd_pkg::poll_t in_poll,
  input  wire logic          consume,
  output logic               poll_valid,
  output scd_pkg::poll_t     poll
);
  import scd_pkg::*;

  logic  valid_r, valid_nxt;
  poll_t poll_r;

  assign in_ready   = !valid_r || consume;
  assign poll_valid = valid_r;
  assign poll       = poll_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on every input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r <= in_poll;
    end
  end

endmodule
`default_nettype wire

// ----- design/scd_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_decoder
// Decode state (mode, skip count, ring slot) and the per-poll decode logic.
// ----------------------------------------------------------------------------
module scd_decoder #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire scd_pkg::poll_t poll,
  input  wire logic           advance,
  output logic                emit,
  output scd_pkg::result_t    result
);
  import scd_pkg::*;

  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  mode_t          mode_r, mode_nxt;
  skip_cnt_t      cnt_r, cnt_nxt;
  logic [RW-1:0]  slot_r, slot_nxt;
  logic [RW+3:0]  slot_ext;
  logic           dropped;
  logic           as_idle;
  key_t           ch;

  assign dropped  = poll.data_ready && (poll.timeout_error || poll.parity_error);
  assign slot_ext = {4'b0, slot_r};

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    as_idle  = 1'b0;
    ch       = map_code(poll.scan_byte);
    emit     = 1'b0;
    if (!dropped) begin
      unique case (mode_r)
        MODE_SKIP: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - SKIP_PLAIN;
            if (cnt_r == SKIP_PLAIN) begin
              mode_nxt = MODE_IDLE;
            end
          end else begin
            as_idle = 1'b1;
          end
        end
        MODE_CLASS: begin
          mode_nxt = MODE_SKIP;
          if (poll.data_ready && short_class(poll.scan_byte)) begin
            cnt_nxt = SKIP_SHORT;
          end else if (poll.data_ready && poll.scan_byte == CODE_PRTSC) begin
            cnt_nxt = SKIP_PRTSC;
          end else begin
            cnt_nxt = SKIP_LONG;
          end
        end
        default: as_idle = 1'b1;
      endcase
      if (as_idle) begin
        mode_nxt = MODE_IDLE;
        if (poll.data_ready) begin
          if (poll.scan_byte == CODE_EXT0) begin
            mode_nxt = MODE_CLASS;
          end else if (poll.scan_byte == CODE_EXT1) begin
            mode_nxt = MODE_SKIP;
            cnt_nxt  = SKIP_EXT1;
          end else begin
            mode_nxt = MODE_SKIP;
            cnt_nxt  = SKIP_PLAIN;
            emit     = (ch != '0);
          end
        end
      end
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (advance && emit) begin
      slot_nxt = (slot_r == RW'(RING_DEPTH - 1)) ? '0 : slot_r + RW'(1);
    end
  end

  assign result.key_code  = ch;
  assign result.ring_slot = slot_ext[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Skip count is nonzero exactly while skipping.
  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SKIP) == (cnt_r != '0))
    else $error("skip count out of step with mode");

  // Ring slot moves only when a character is emitted.
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && emit) |=> $stable(slot_r))
    else $error("ring slot changed without a character");
`endif

endmodule
`default_nettype wire

// ----- design/scd_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_out_stage
// Result register: hold one decoded character until the sink takes it.
// ----------------------------------------------------------------------------
module scd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire scd_pkg::result_t result,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output scd_pkg::result_t      out_result
);
  import scd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule
`default_nettype wire

// ----- design/scancode_set1_to_ascii_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: a poll is held in the input register after its input transfer; its character
// is then loaded into the result register once that is free, and the sink takes it from there.
// Throughput: one poll per cycle; the input stalls only while a held poll's character
// meets a full result register that the sink is not draining in this cycle.
// Reset: synchronous active-low rst_n returns the decoder to idle, clears the skip
// count and ring slot, and empties both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder_core
// Set-1 scancode to ASCII decoder with prefix skipping and ring slot tagging.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder_core #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scd_in_if.sink     in_ch,
  scd_out_if.source  out_ch
);
  import scd_pkg::*;

  poll_t   in_poll;
  poll_t   poll;
  logic    poll_valid;
  logic    emit;
  logic    advance;
  logic    load;
  logic    out_free;
  result_t result;
  result_t out_result;

  assign in_poll.data_ready    = in_ch.data_ready;
  assign in_poll.timeout_error = in_ch.timeout_error;
  assign in_poll.parity_error  = in_ch.parity_error;
  assign in_poll.scan_byte     = in_ch.scan_byte;

  // Advance the held poll when it makes no character, or when the result
  // register can take the character in this cycle.
  assign advance = poll_valid && (out_free || !emit);
  assign load    = advance && emit;

  scd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_poll    (in_poll),
    .consume    (advance),
    .poll_valid (poll_valid),
    .poll       (poll)
  );

  scd_decoder #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .poll    (poll),
    .advance (advance),
    .emit    (emit),
    .result  (result)
  );

  scd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.key_code  = out_result.key_code;
  assign out_ch.ring_slot = out_result.ring_slot;

`ifndef NO_ASSERTIONS
  // Never overwrite a character the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // A stalled input means a poll is held and blocked on the result side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (poll_valid && emit && !out_free))
    else $error("input stalled without cause");

  // Every emitted character carries a nonzero code.
  a_nonzero_key: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_ch.valid && out_ch.key_code != '0))
    else $error("zero key code emitted");
`endif

endmodule
`default_nettype wire
